// ===== hw/rtl/acc_alu_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package acc_alu_pkg;

    localparam int DATA_WIDTH = 32;
    localparam int CNT_W      = $clog2(DATA_WIDTH);

    typedef logic signed [DATA_WIDTH-1:0] t_data;

    typedef enum logic [2:0] {
        MODE_LOAD = 3'd0,
        MODE_ADD  = 3'd1,
        MODE_SUB  = 3'd2,
        MODE_MUL  = 3'd3,
        MODE_DIV  = 3'd4
    } t_mode;

    typedef enum logic [1:0] {
        STAT_OK      = 2'd0,
        STAT_DIVZERO = 2'd1,
        STAT_INVALID = 2'd2,
        STAT_IGNORED = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_MUL,
        ST_DIV,
        ST_FINISH
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic start;
        logic mul_step;
        logic div_step;
        logic finish;
    } t_dp_cmd;

    // datapath -> controller
    typedef struct packed {
        logic in_is_mul;
        logic in_is_div;
        logic out_free;
    } t_dp_stat;

endpackage

`default_nettype wire

// ===== hw/rtl/acc_alu_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module acc_alu_ctrl (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire acc_alu_pkg::t_dp_stat i_stat,
    output acc_alu_pkg::t_dp_cmd       o_cmd
);
    import acc_alu_pkg::*;

    t_state           r_state;
    t_state           n_state;
    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;
    logic             accept;
    logic             last_iter;

    assign accept    = i_in_valid && (r_state == ST_IDLE);
    assign last_iter = (r_count == CNT_W'(DATA_WIDTH - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_count <= '0;
        end else begin
            r_state <= n_state;
            r_count <= n_count;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        n_count = r_count;
        unique case (r_state)
            ST_IDLE: begin
                n_count = '0;
                if (accept) begin
                    if (i_stat.in_is_mul) begin
                        n_state = ST_MUL;
                    end else if (i_stat.in_is_div) begin
                        n_state = ST_DIV;
                    end else begin
                        n_state = ST_FINISH;
                    end
                end
            end
            ST_MUL, ST_DIV: begin
                n_count = r_count + CNT_W'(1);
                if (last_iter) begin
                    n_state = ST_FINISH;
                end
            end
            ST_FINISH: begin
                if (i_stat.out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // outputs
    always_comb begin
        o_in_stall = 1'b1;
        o_cmd      = '0;
        unique case (r_state)
            ST_IDLE: begin
                o_in_stall  = 1'b0;
                o_cmd.start = accept;
            end
            ST_MUL:    o_cmd.mul_step = 1'b1;
            ST_DIV:    o_cmd.div_step = 1'b1;
            ST_FINISH: o_cmd.finish   = i_stat.out_free;
            default:   o_cmd          = '0;
        endcase
    end

endmodule

`default_nettype wire

// ===== hw/rtl/acc_alu_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module acc_alu_dp (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire acc_alu_pkg::t_dp_cmd i_cmd,
    output acc_alu_pkg::t_dp_stat     o_stat,
    input  wire logic [2:0]           i_mode,
    input  wire acc_alu_pkg::t_data   i_operand,
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output acc_alu_pkg::t_data        o_accumulator_out,
    output logic [1:0]                o_status
);
    import acc_alu_pkg::*;

    localparam int DW = DATA_WIDTH;

    // architectural state
    logic [DW-1:0] r_acc;
    logic          r_halted;
    // latched request
    logic [2:0]    r_mode;
    logic [DW-1:0] r_opnd;
    // iteration registers
    logic [DW-1:0] r_prod;
    logic [DW-1:0] r_mcand;
    logic [DW-1:0] r_mplier;
    logic [DW-1:0] r_rem;
    logic [DW-1:0] r_dvd;
    logic [DW-1:0] r_dvs;
    // output register
    logic          r_out_valid;
    logic [DW-1:0] r_out_acc;
    logic [1:0]    r_out_status;

    logic [DW-1:0] opnd_u;
    logic [DW-1:0] acc_mag;
    logic [DW-1:0] opnd_mag;
    logic [DW:0]   rem_sh;
    logic [DW:0]   rem_diff;
    logic          rem_ge;
    logic [DW-1:0] quot;
    logic [DW-1:0] n_acc;
    logic          n_halted;
    t_status       n_status;

    assign opnd_u   = DW'(i_operand);
    assign acc_mag  = r_acc[DW-1] ? (~r_acc + DW'(1)) : r_acc;
    assign opnd_mag = opnd_u[DW-1] ? (~opnd_u + DW'(1)) : opnd_u;

    assign o_stat.in_is_mul = (i_mode == MODE_MUL) && !r_halted;
    assign o_stat.in_is_div = (i_mode == MODE_DIV) && !r_halted && (opnd_u != '0);
    assign o_stat.out_free  = !r_out_valid || !i_out_stall;

    // restoring divide step on magnitudes
    assign rem_sh   = {r_rem, r_dvd[DW-1]};
    assign rem_diff = rem_sh - {1'b0, r_dvs};
    assign rem_ge   = !rem_diff[DW];
    assign quot     = (r_acc[DW-1] ^ r_opnd[DW-1]) ? (~r_dvd + DW'(1)) : r_dvd;

    // result of the latched request
    always_comb begin
        n_acc    = r_acc;
        n_halted = r_halted;
        n_status = STAT_OK;
        if (r_mode == MODE_LOAD) begin
            n_acc    = r_opnd;
            n_halted = 1'b0;
        end else if (r_halted) begin
            n_status = STAT_IGNORED;
        end else begin
            case (r_mode)
                MODE_ADD: n_acc = r_acc + r_opnd;
                MODE_SUB: n_acc = r_acc - r_opnd;
                MODE_MUL: n_acc = r_prod;
                MODE_DIV: begin
                    if (r_opnd == '0) begin
                        n_status = STAT_DIVZERO;
                        n_halted = 1'b1;
                    end else begin
                        n_acc = quot;
                    end
                end
                default: begin
                    n_status = STAT_INVALID;
                    n_halted = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc       <= '0;
            r_halted    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.finish) begin
                r_acc       <= n_acc;
                r_halted    <= n_halted;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_mode   <= i_mode;
            r_opnd   <= opnd_u;
            r_prod   <= '0;
            r_mcand  <= r_acc;
            r_mplier <= opnd_u;
            r_rem    <= '0;
            r_dvd    <= acc_mag;
            r_dvs    <= opnd_mag;
        end
        if (i_cmd.mul_step) begin
            if (r_mplier[0]) begin
                r_prod <= r_prod + r_mcand;
            end
            r_mcand  <= {r_mcand[DW-2:0], 1'b0};
            r_mplier <= {1'b0, r_mplier[DW-1:1]};
        end
        if (i_cmd.div_step) begin
            r_rem <= rem_ge ? rem_diff[DW-1:0] : rem_sh[DW-1:0];
            r_dvd <= {r_dvd[DW-2:0], rem_ge};
        end
        if (i_cmd.finish) begin
            r_out_acc    <= n_acc;
            r_out_status <= n_status;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_accumulator_out = t_data'(r_out_acc);
    assign o_status          = r_out_status;

endmodule

`default_nettype wire

// ===== hw/rtl/accumulator_alu_chain.sv =====
// Sequence: load, add, subtract, errors and requests ignored while halted go from request
// accept straight to finish; a multiply or nonzero divide that runs takes accept, then
// 32 radix-2 shift-add or shift-subtract steps, then finish.
// Requests: one at a time; the next is taken once the result is in the
// output register, and finish waits while the output register is held by a stall.
// Reset (synchronous, active low): accumulator 0, chain not halted, no result pending.
`timescale 1ns / 1ps
`default_nettype none

module accumulator_alu_chain (
    input  wire logic               i_clk,
    input  wire logic               i_rst_n,
    input  wire logic               i_in_valid,
    output logic                    o_in_stall,
    input  wire logic [2:0]         i_mode,
    input  wire acc_alu_pkg::t_data i_operand,
    output logic                    o_out_valid,
    input  wire logic               i_out_stall,
    output acc_alu_pkg::t_data      o_accumulator_out,
    output logic [1:0]              o_status
);
    import acc_alu_pkg::*;

    t_dp_cmd  cmd;
    t_dp_stat stat;

    acc_alu_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_stat     (stat),
        .o_cmd      (cmd)
    );

    acc_alu_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_stat            (stat),
        .i_mode            (i_mode),
        .i_operand         (i_operand),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_accumulator_out (o_accumulator_out),
        .o_status          (o_status)
    );

endmodule

`default_nettype wire
